FILE: rtl/gpgb_pkg.sv
// Shared types, constants and tables for the gait playback block.
package gpgb_pkg;

    localparam int JOINTS     = 16;
    localparam int COL_W      = 4;
    localparam int ANGLE_W    = 24;
    localparam int GYRO_W     = 12;
    localparam int GAIN_W     = 10;
    localparam int POS_W      = 19;
    localparam int PGAIN_W    = 8;
    localparam int ID_W       = 5;
    localparam int ROWCNT_W   = 9;
    localparam int SCALED_W   = 21;
    localparam int TERM_W     = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int IN_DATA_W  = 48;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = 32;

    // gyro pipeline depth, sample register to term register
    localparam int GYRO_LAT = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // 251000/pi as unsigned Q17.12
    localparam logic [28:0] RAD_TO_UNITS = 29'd327253121;
    // 490.23 * 100; the /25600 is split into >>10 and /25
    localparam logic [15:0] GYRO_NUM     = 16'd49023;
    // ceil(2^32/25), exact for dividends below 2^30
    localparam logic [27:0] DIV25_RECIP  = 28'd171798692;
    localparam logic [PGAIN_W-1:0] ARM_P_GAIN = 8'd16;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REWIND = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BALANCE_ENABLE   = 3'd0,
        REG_HIP_ROLL_GAIN    = 3'd1,
        REG_ANKLE_ROLL_GAIN  = 3'd2,
        REG_KNEE_GAIN        = 3'd3,
        REG_ANKLE_PITCH_GAIN = 3'd4,
        REG_HIP_PITCH_OFFSET = 3'd5,
        REG_LEG_P_GAIN       = 3'd6,
        REG_ROW_COUNT        = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TICK,
        OP_REWIND
    } op_t;

    // load: angle word; tick: {pitch_gyro, roll_gyro}
    typedef struct packed {
        op_t                 op;
        logic [ANGLE_W-1:0]  payload;
    } cmd_t;

    typedef struct packed {
        logic                balance_enable;
        logic [GAIN_W-1:0]   hip_roll_gain;
        logic [GAIN_W-1:0]   ankle_roll_gain;
        logic [GAIN_W-1:0]   knee_gain;
        logic [GAIN_W-1:0]   ankle_pitch_gain;
        logic [POS_W-1:0]    hip_pitch_offset;
        logic [PGAIN_W-1:0]  leg_p_gain;
        logic [ROWCNT_W-1:0] row_count;
    } cfg_t;

    // signed two's complement terms
    typedef struct packed {
        logic [TERM_W-1:0] hip_roll;
        logic [TERM_W-1:0] ankle_roll;
        logic [TERM_W-1:0] knee;
        logic [TERM_W-1:0] ankle_pitch;
    } gyro_terms_t;

    function automatic logic [ID_W-1:0] joint_id(input logic [COL_W-1:0] col);
        logic [ID_W-1:0] id;
        case (col)
            4'd0:    id = 5'd15;
            4'd1:    id = 5'd17;
            4'd2:    id = 5'd19;
            4'd3:    id = 5'd21;
            4'd4:    id = 5'd23;
            4'd5:    id = 5'd25;
            4'd6:    id = 5'd16;
            4'd7:    id = 5'd18;
            4'd8:    id = 5'd20;
            4'd9:    id = 5'd22;
            4'd10:   id = 5'd24;
            4'd11:   id = 5'd26;
            4'd12:   id = 5'd1;
            4'd13:   id = 5'd2;
            4'd14:   id = 5'd7;
            default: id = 5'd8;
        endcase
        return id;
    endfunction

endpackage

FILE: rtl/gait_playback_gyro_balance.sv
// Top level: gait table playback with gyro balance, config registers and wiring.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata: angle_word, roll_gyro, pitch_gyro
//           |     |                    | tuser: kind
//  m_       | out | m_tvalid/m_tready  | tdata: joint_id, position, p_gain; tlast
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Load and rewind items are handled in the engine's idle state. A tick latches its
// gyro samples, waits in the gyro state while the gyro multiplier pipeline works,
// then makes 16 table reads, one per cycle while m_tready does not stall the output,
// and drains the read pipeline; a four-entry command queue lets the input side keep
// taking transfers meanwhile. Reset (aresetn low, synchronous) clears pointers,
// play row and queue and sets config to its defaults; table contents are undefined
// until loaded. A stalled m_tready freezes the read pipeline in place.
module gait_playback_gyro_balance #(
    parameter int MAX_ROWS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gpgb_pkg::IN_DATA_W-1:0]     s_tdata,   // angle_word[23:0], roll_gyro[35:24], pitch_gyro[47:36]
    input  logic [gpgb_pkg::KIND_W-1:0]        s_tuser,   // kind[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gpgb_pkg::OUT_DATA_W-1:0]    m_tdata,   // joint_id[4:0], position[23:5], p_gain[31:24]
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gpgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpgb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    gpgb_pkg::cfg_t             cfg_reg;
    gpgb_pkg::cmd_t             push_cmd;
    gpgb_pkg::cmd_t             head_cmd;
    gpgb_pkg::gyro_terms_t      terms;
    logic                       push;
    logic                       queue_full;
    logic                       head_valid;
    logic                       pop;
    logic [gpgb_pkg::GYRO_W-1:0] roll_sample;
    logic [gpgb_pkg::GYRO_W-1:0] pitch_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.balance_enable   <= 1'b1;
            cfg_reg.hip_roll_gain    <= 10'd128;
            cfg_reg.ankle_roll_gain  <= 10'd256;
            cfg_reg.knee_gain        <= 10'd77;
            cfg_reg.ankle_pitch_gain <= 10'd230;
            cfg_reg.hip_pitch_offset <= '0;
            cfg_reg.leg_p_gain       <= 8'd64;
            cfg_reg.row_count        <= 9'd1;
        end else if (cfg_valid) begin
            unique case (gpgb_pkg::cfg_idx_t'(cfg_index))
                gpgb_pkg::REG_BALANCE_ENABLE:   cfg_reg.balance_enable   <= cfg_data[0];
                gpgb_pkg::REG_HIP_ROLL_GAIN:    cfg_reg.hip_roll_gain    <= cfg_data[9:0];
                gpgb_pkg::REG_ANKLE_ROLL_GAIN:  cfg_reg.ankle_roll_gain  <= cfg_data[9:0];
                gpgb_pkg::REG_KNEE_GAIN:        cfg_reg.knee_gain        <= cfg_data[9:0];
                gpgb_pkg::REG_ANKLE_PITCH_GAIN: cfg_reg.ankle_pitch_gain <= cfg_data[9:0];
                gpgb_pkg::REG_HIP_PITCH_OFFSET: cfg_reg.hip_pitch_offset <= cfg_data[18:0];
                gpgb_pkg::REG_LEG_P_GAIN:       cfg_reg.leg_p_gain       <= cfg_data[7:0];
                gpgb_pkg::REG_ROW_COUNT:        cfg_reg.row_count        <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    gpgb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    gpgb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    gpgb_gyro u_gyro (
        .aclk       (aclk),
        .roll_gyro  (roll_sample),
        .pitch_gyro (pitch_sample),
        .cfg        (cfg_reg),
        .terms      (terms)
    );

    gpgb_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .cfg          (cfg_reg),
        .terms        (terms),
        .roll_sample  (roll_sample),
        .pitch_sample (pitch_sample),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

FILE: rtl/gpgb_queue.sv
// Short command queue between the front end and the playback engine.
module gpgb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gpgb_pkg::cmd_t     push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output gpgb_pkg::cmd_t     head_cmd
);

    gpgb_pkg::cmd_t                 entry_reg [gpgb_pkg::QUEUE_DEPTH];
    logic [gpgb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [gpgb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [gpgb_pkg::QPTR_W:0]      count_reg;

    assign full       = (count_reg == (gpgb_pkg::QPTR_W+1)'(gpgb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/gpgb_front.sv
// Input side: takes stream transfers, decodes the kind and queues commands.
module gpgb_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gpgb_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [gpgb_pkg::KIND_W-1:0]       s_tuser,
    input  logic                              queue_full,
    output logic                              push,
    output gpgb_pkg::cmd_t                    push_cmd
);

    logic keep;

    assign s_tready = !queue_full;

    always_comb begin
        keep             = 1'b1;
        push_cmd.op      = gpgb_pkg::OP_LOAD;
        push_cmd.payload = '0;
        unique case (s_tuser)
            gpgb_pkg::KIND_LOAD: begin
                push_cmd.op      = gpgb_pkg::OP_LOAD;
                push_cmd.payload = s_tdata[gpgb_pkg::ANGLE_W-1:0];
            end
            gpgb_pkg::KIND_TICK: begin
                push_cmd.op      = gpgb_pkg::OP_TICK;
                push_cmd.payload = s_tdata[47:24];
            end
            gpgb_pkg::KIND_REWIND: begin
                push_cmd.op = gpgb_pkg::OP_REWIND;
            end
            default: begin
                // unused kind: consumed and dropped
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && !queue_full && keep;

endmodule

FILE: rtl/gpgb_gyro.sv
// Four-lane pipeline computing the gyro balance terms trunc(s*g*490.23/256).
module gpgb_gyro (
    input  logic                           aclk,
    input  logic [gpgb_pkg::GYRO_W-1:0]    roll_gyro,
    input  logic [gpgb_pkg::GYRO_W-1:0]    pitch_gyro,
    input  gpgb_pkg::cfg_t                 cfg,
    output gpgb_pkg::gyro_terms_t          terms
);

    localparam int LANES = 4;

    logic [gpgb_pkg::GYRO_W-1:0]   sample      [LANES];
    logic [gpgb_pkg::GAIN_W-1:0]   gain        [LANES];
    logic [gpgb_pkg::GYRO_W-1:0]   mag         [LANES];
    logic [21:0]                   prod_a_full [LANES];
    logic [36:0]                   prod_b_full [LANES];
    logic [54:0]                   recip_full  [LANES];

    logic                          neg_a_reg   [LANES];
    logic [20:0]                   prod_a_reg  [LANES];
    logic                          neg_b_reg   [LANES];
    logic [36:0]                   prod_b_reg  [LANES];
    logic                          neg_c_reg   [LANES];
    logic [22:0]                   quot_c_reg  [LANES];
    logic [gpgb_pkg::TERM_W-1:0]   term_reg    [LANES];

    assign sample[0] = roll_gyro;
    assign sample[1] = roll_gyro;
    assign sample[2] = pitch_gyro;
    assign sample[3] = pitch_gyro;
    assign gain[0]   = cfg.hip_roll_gain;
    assign gain[1]   = cfg.ankle_roll_gain;
    assign gain[2]   = cfg.knee_gain;
    assign gain[3]   = cfg.ankle_pitch_gain;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            mag[i] = sample[i][gpgb_pkg::GYRO_W-1] ? (12'd0 - sample[i]) : sample[i];
            prod_a_full[i] = {10'd0, mag[i]} * {12'd0, gain[i]};
            prod_b_full[i] = {16'd0, prod_a_reg[i]} * {21'd0, gpgb_pkg::GYRO_NUM};
            // >>10 then divide by 25 through the reciprocal
            recip_full[i]  = {28'd0, prod_b_reg[i][36:10]} * {27'd0, gpgb_pkg::DIV25_RECIP};
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            neg_a_reg[i]  <= sample[i][gpgb_pkg::GYRO_W-1];
            prod_a_reg[i] <= prod_a_full[i][20:0];
            neg_b_reg[i]  <= neg_a_reg[i];
            prod_b_reg[i] <= prod_b_full[i];
            neg_c_reg[i]  <= neg_b_reg[i];
            quot_c_reg[i] <= recip_full[i][54:32];
            term_reg[i]   <= neg_c_reg[i] ? (23'd0 - quot_c_reg[i]) : quot_c_reg[i];
        end
    end

    assign terms.hip_roll    = term_reg[0];
    assign terms.ankle_roll  = term_reg[1];
    assign terms.knee        = term_reg[2];
    assign terms.ankle_pitch = term_reg[3];

endmodule

FILE: rtl/gpgb_back.sv
// Playback engine: gait table memory, command sequencer and output pipeline.
module gpgb_back #(
    parameter int MAX_ROWS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cmd_valid,
    input  gpgb_pkg::cmd_t                     cmd,
    output logic                               cmd_pop,
    input  gpgb_pkg::cfg_t                     cfg,
    input  gpgb_pkg::gyro_terms_t              terms,
    output logic [gpgb_pkg::GYRO_W-1:0]        roll_sample,
    output logic [gpgb_pkg::GYRO_W-1:0]        pitch_sample,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gpgb_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    localparam int DEPTH  = MAX_ROWS * gpgb_pkg::JOINTS;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = ROW_W + gpgb_pkg::COL_W;
    localparam int RCW_M  = $clog2(MAX_ROWS + 1);
    localparam int RCW    = (RCW_M > gpgb_pkg::ROWCNT_W) ? RCW_M : gpgb_pkg::ROWCNT_W;
    localparam int SUM_W  = 25;
    localparam int WAIT_W = $clog2(gpgb_pkg::GYRO_LAT);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(MAX_ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [gpgb_pkg::COL_W-1:0] LAST_COL = gpgb_pkg::COL_W'(gpgb_pkg::JOINTS - 1);
    localparam logic [gpgb_pkg::COL_W-1:0] FIRST_ARM_COL = 4'd12;
    localparam logic signed [SUM_W-1:0] POS_MAX_S = 25'sd262143;
    localparam logic signed [SUM_W-1:0] POS_MIN_S = -25'sd262144;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GYRO,
        ST_STREAM,
        ST_DRAIN
    } state_t;

    state_t                              state_reg;
    logic [ADDR_W-1:0]                   load_ptr_reg;
    logic [ROW_W-1:0]                    play_row_reg;
    logic [ROW_W-1:0]                    row_reg;
    logic [gpgb_pkg::COL_W-1:0]          col_reg;
    logic [WAIT_W-1:0]                   wait_reg;
    logic                                s1_valid_reg;
    logic                                s2_valid_reg;
    logic                                out_valid_reg;

    logic [gpgb_pkg::ANGLE_W-1:0]        mem [DEPTH];
    logic [gpgb_pkg::ANGLE_W-1:0]        rd_data_reg;
    logic [gpgb_pkg::GYRO_W-1:0]         roll_reg;
    logic [gpgb_pkg::GYRO_W-1:0]         pitch_reg;
    logic [gpgb_pkg::COL_W-1:0]          s1_col_reg;
    logic [gpgb_pkg::COL_W-1:0]          s2_col_reg;
    logic signed [gpgb_pkg::SCALED_W-1:0] scaled_reg;
    logic [gpgb_pkg::OUT_DATA_W-1:0]     out_data_reg;
    logic                                out_last_reg;

    logic                                en;
    logic                                issue;
    logic                                mem_we;
    logic [ADDR_W-1:0]                   load_ptr_next;
    logic [RCW-1:0]                      rows_ext;
    logic [RCW-1:0]                      rows_clamped;
    logic [RCW-1:0]                      rows_last;
    logic [ROW_W-1:0]                    row_next;
    logic [gpgb_pkg::ANGLE_W-1:0]        angle_mag;
    logic [52:0]                         scale_full;
    logic [gpgb_pkg::SCALED_W-1:0]       scale_mag;
    logic signed [gpgb_pkg::SCALED_W-1:0] scaled_next;
    logic signed [SUM_W-1:0]             offset_val;
    logic signed [SUM_W-1:0]             term_val;
    logic signed [SUM_W-1:0]             sum_val;
    logic [gpgb_pkg::POS_W-1:0]          position_next;
    logic [gpgb_pkg::PGAIN_W-1:0]        p_gain_next;

    // whole pipeline moves when the output register is free or being taken
    assign en      = !out_valid_reg || m_tready;
    assign issue   = (state_reg == ST_STREAM);
    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign mem_we  = cmd_pop && (cmd.op == gpgb_pkg::OP_LOAD);

    assign load_ptr_next = (load_ptr_reg == LAST_ADDR) ? '0 : load_ptr_reg + 1'b1;

    // play row held at row_count-1, with row_count clamped to 1..MAX_ROWS
    always_comb begin
        rows_ext = RCW'(cfg.row_count);
        if (rows_ext == '0) begin
            rows_clamped = RCW'(1);
        end else if (rows_ext > RCW'(MAX_ROWS)) begin
            rows_clamped = RCW'(MAX_ROWS);
        end else begin
            rows_clamped = rows_ext;
        end
        rows_last = rows_clamped - 1'b1;
        row_next  = (RCW'(play_row_reg) < rows_last) ? play_row_reg : rows_last[ROW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            load_ptr_reg  <= '0;
            play_row_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            wait_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        unique case (cmd.op)
                            gpgb_pkg::OP_LOAD: begin
                                load_ptr_reg <= load_ptr_next;
                            end
                            gpgb_pkg::OP_REWIND: begin
                                load_ptr_reg <= '0;
                                play_row_reg <= '0;
                            end
                            gpgb_pkg::OP_TICK: begin
                                row_reg  <= row_next;
                                wait_reg <= '0;
                                if (play_row_reg != LAST_ROW) begin
                                    play_row_reg <= play_row_reg + 1'b1;
                                end
                                state_reg <= ST_GYRO;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_GYRO: begin
                    wait_reg <= wait_reg + 1'b1;
                    if (wait_reg == WAIT_W'(gpgb_pkg::GYRO_LAT - 1)) begin
                        col_reg   <= '0;
                        state_reg <= ST_STREAM;
                    end
                end
                ST_STREAM: begin
                    if (en) begin
                        col_reg <= col_reg + 1'b1;
                        if (col_reg == LAST_COL) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    // gyro terms must stay put until the last read has used them
                    if (!s1_valid_reg && !s2_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[load_ptr_reg] <= cmd.payload;
        end
        if (issue && en) begin
            rd_data_reg <= mem[{row_reg, col_reg}];
        end
    end

    // angle * 251000/pi, truncated toward zero
    always_comb begin
        angle_mag   = rd_data_reg[gpgb_pkg::ANGLE_W-1] ? (24'd0 - rd_data_reg) : rd_data_reg;
        scale_full  = {29'd0, angle_mag} * {24'd0, gpgb_pkg::RAD_TO_UNITS};
        scale_mag   = scale_full[52:32];
        scaled_next = rd_data_reg[gpgb_pkg::ANGLE_W-1] ? $signed(21'd0 - scale_mag)
                                                       : $signed(scale_mag);
    end

    always_comb begin
        offset_val = '0;
        term_val   = '0;
        case (s2_col_reg)
            4'd2:    offset_val = SUM_W'($signed(cfg.hip_pitch_offset));
            4'd8:    offset_val = -SUM_W'($signed(cfg.hip_pitch_offset));
            default: ;
        endcase
        case (s2_col_reg) inside
            4'd1, 4'd7:  term_val = -SUM_W'($signed(terms.hip_roll));
            4'd5, 4'd11: term_val = -SUM_W'($signed(terms.ankle_roll));
            4'd3:        term_val = SUM_W'($signed(terms.knee));
            4'd9:        term_val = -SUM_W'($signed(terms.knee));
            4'd4:        term_val = -SUM_W'($signed(terms.ankle_pitch));
            4'd10:       term_val = SUM_W'($signed(terms.ankle_pitch));
            default: ;
        endcase
        if (!cfg.balance_enable) begin
            term_val = '0;
        end
        sum_val = SUM_W'(scaled_reg) + offset_val + term_val;
        if (sum_val > POS_MAX_S) begin
            position_next = 19'h3FFFF;
        end else if (sum_val < POS_MIN_S) begin
            position_next = 19'h40000;
        end else begin
            position_next = sum_val[gpgb_pkg::POS_W-1:0];
        end
        p_gain_next = (s2_col_reg < FIRST_ARM_COL) ? cfg.leg_p_gain : gpgb_pkg::ARM_P_GAIN;
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop && (cmd.op == gpgb_pkg::OP_TICK)) begin
            roll_reg  <= cmd.payload[11:0];
            pitch_reg <= cmd.payload[23:12];
        end
        if (en) begin
            s1_col_reg   <= col_reg;
            s2_col_reg   <= s1_col_reg;
            scaled_reg   <= scaled_next;
            out_data_reg <= {p_gain_next, position_next, gpgb_pkg::joint_id(s2_col_reg)};
            out_last_reg <= (s2_col_reg == LAST_COL);
        end
    end

    assign roll_sample  = roll_reg;
    assign pitch_sample = pitch_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tlast      = out_last_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the gait playback block: directed table, then random gaits.
module tb_top;
    import gpgb_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int ROWS_MAX     = 256;
    localparam int TABLE_WORDS  = ROWS_MAX * JOINTS;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_CAP   = 200;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;    // ignored by the block

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [POS_W-1:0]   pos;
        logic [PGAIN_W-1:0] gain;
        logic               last;
    } joint_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ANGLE_W-1:0] angle;
        logic [GYRO_W-1:0]  roll;
        logic [GYRO_W-1:0]  pitch;
        logic [4:0]         reps;
        logic               pinned;      // expected position typed in for every joint
        logic [POS_W-1:0]   pinned_pos;
    } step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    gait_playback_gyro_balance dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // predictor state
    logic [ANGLE_W-1:0] gait_mem [TABLE_WORDS];
    bit                 gait_written [TABLE_WORDS];
    logic [11:0]        load_ptr = '0;
    logic [7:0]         play_row = '0;
    cfg_t               regs;

    joint_cmd_t   joint_cmds_q[$];
    int unsigned  mismatches = 0;
    int unsigned  gait_items = 0;
    int unsigned  cycle_count = 0;
    int unsigned  s_idle_pct = 0;
    int unsigned  r_idle_pct = 0;
    bit           hold_go = 1'b0;
    bit           rx_hold = 1'b0;
    step_t        steps [9];

    function automatic logic [ID_W-1:0] servo_of(input int col);
        case (col)
            0: return 5'd15;   1: return 5'd17;   2: return 5'd19;   3: return 5'd21;
            4: return 5'd23;   5: return 5'd25;   6: return 5'd16;   7: return 5'd18;
            8: return 5'd20;   9: return 5'd22;  10: return 5'd24;  11: return 5'd26;
            12: return 5'd1;  13: return 5'd2;   14: return 5'd7;
            default: return 5'd8;
        endcase
    endfunction

    // radians Q3.20 to motor units, truncated toward zero
    function automatic longint to_units(input logic [ANGLE_W-1:0] w);
        longint a;
        longint mag;
        a = longint'(signed'(w));
        mag = (a < 0) ? -a : a;
        mag = (mag * longint'(327253121)) >>> 32;
        return (a < 0) ? -mag : mag;
    endfunction

    function automatic longint gyro_corr(input longint s, input longint g);
        return (s * g * longint'(49023)) / longint'(25600);
    endfunction

    function automatic int active_row();
        int rows;
        rows = (regs.row_count == 0) ? 1 : int'(regs.row_count);
        if (rows > ROWS_MAX) rows = ROWS_MAX;
        return (int'(play_row) < rows - 1) ? int'(play_row) : rows - 1;
    endfunction

    function automatic bit row_loaded();
        int r;
        r = active_row();
        for (int j = 0; j < JOINTS; j++) begin
            if (!gait_written[r * JOINTS + j]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void apply_item(input logic [KIND_W-1:0] kind,
                                       input logic [ANGLE_W-1:0] angle,
                                       input logic [GYRO_W-1:0] roll,
                                       input logic [GYRO_W-1:0] pitch,
                                       input logic pinned,
                                       input logic [POS_W-1:0] pinned_pos);
        longint     pos [JOINTS];
        longint     off, hip, ankle, knee, apitch, v;
        int         r;
        joint_cmd_t cmd;
        case (kind)
            KIND_LOAD: begin
                gait_mem[load_ptr] = angle;
                gait_written[load_ptr] = 1'b1;
                load_ptr = load_ptr + 1'b1;
            end
            KIND_REWIND: begin
                load_ptr = '0;
                play_row = '0;
            end
            KIND_TICK: begin
                r = active_row();
                for (int j = 0; j < JOINTS; j++) pos[j] = to_units(gait_mem[r * JOINTS + j]);
                off = longint'(signed'(regs.hip_pitch_offset));
                pos[2] += off;
                pos[8] -= off;
                if (regs.balance_enable) begin
                    hip    = gyro_corr(longint'(signed'(roll)), longint'(regs.hip_roll_gain));
                    ankle  = gyro_corr(longint'(signed'(roll)), longint'(regs.ankle_roll_gain));
                    knee   = gyro_corr(longint'(signed'(pitch)), longint'(regs.knee_gain));
                    apitch = gyro_corr(longint'(signed'(pitch)), longint'(regs.ankle_pitch_gain));
                    pos[1] -= hip;
                    pos[7] -= hip;
                    pos[5] -= ankle;
                    pos[11] -= ankle;
                    pos[3] += knee;
                    pos[9] -= knee;
                    pos[4] -= apitch;
                    pos[10] += apitch;
                end
                for (int j = 0; j < JOINTS; j++) begin
                    v = pos[j];
                    if (v > 262143) v = 262143;
                    if (v < -262144) v = -262144;
                    cmd.id   = servo_of(j);
                    cmd.pos  = pinned ? pinned_pos : v[POS_W-1:0];
                    cmd.gain = (j < 12) ? regs.leg_p_gain : ARM_P_GAIN;
                    cmd.last = (j == JOINTS - 1);
                    joint_cmds_q.push_back(cmd);
                end
                if (play_row < ROWS_MAX - 1) play_row = play_row + 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] rand_angle();
        logic [31:0] t;
        if ($urandom_range(1)) return $urandom;
        t = $urandom_range(1048575) - 32'd524288;
        return t[ANGLE_W-1:0];
    endfunction

    function automatic logic [GYRO_W-1:0] rand_gyro();
        logic [31:0] t;
        if ($urandom_range(99) < 40) return $urandom;
        t = $urandom_range(128) - 32'd64;
        return t[GYRO_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // valid stays high from the accepting edge to the next falling edge only
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ANGLE_W-1:0] angle,
                             input logic [GYRO_W-1:0] roll, input logic [GYRO_W-1:0] pitch,
                             input logic pinned, input logic [POS_W-1:0] pinned_pos);
        @(negedge aclk);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pitch, roll, angle};
        do @(posedge aclk); while (!s_tready);
        apply_item(kind, angle, roll, pitch, pinned, pinned_pos);
        if (kind != KIND_NONE) gait_items++;
    endtask

    task automatic send_noise();
        send_item(KIND_NONE, $urandom, $urandom, $urandom, 1'b0, '0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BALANCE_ENABLE:   regs.balance_enable   = data[0];
            REG_HIP_ROLL_GAIN:    regs.hip_roll_gain    = data[GAIN_W-1:0];
            REG_ANKLE_ROLL_GAIN:  regs.ankle_roll_gain  = data[GAIN_W-1:0];
            REG_KNEE_GAIN:        regs.knee_gain        = data[GAIN_W-1:0];
            REG_ANKLE_PITCH_GAIN: regs.ankle_pitch_gain = data[GAIN_W-1:0];
            REG_HIP_PITCH_OFFSET: regs.hip_pitch_offset = data[POS_W-1:0];
            REG_LEG_P_GAIN:       regs.leg_p_gain       = data[PGAIN_W-1:0];
            default:              regs.row_count        = data[ROWCNT_W-1:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input int en, input int hr, input int ar, input int kn,
                                input int ap, input int off, input int pg, input int rc);
        write_reg(REG_BALANCE_ENABLE,   CFG_DATA_W'(en));
        write_reg(REG_HIP_ROLL_GAIN,    CFG_DATA_W'(hr));
        write_reg(REG_ANKLE_ROLL_GAIN,  CFG_DATA_W'(ar));
        write_reg(REG_KNEE_GAIN,        CFG_DATA_W'(kn));
        write_reg(REG_ANKLE_PITCH_GAIN, CFG_DATA_W'(ap));
        write_reg(REG_HIP_PITCH_OFFSET, CFG_DATA_W'(off));
        write_reg(REG_LEG_P_GAIN,       CFG_DATA_W'(pg));
        write_reg(REG_ROW_COUNT,        CFG_DATA_W'(rc));
    endtask

    task automatic program_random(input int rc);
        program_regs($urandom_range(1), $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(1023), $urandom_range(1023),
                     int'($urandom_range(502000)) - 251000, $urandom_range(255), rc);
    endtask

    // loads and rewinds leave no result behind, so allow the engine to finish them too
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (joint_cmds_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // rewind, load a gait of whole rows plus extra words, then play it mixed with noise, stray rewinds and loads
    task automatic gait_run(input int rows, input int extra, input int ticks);
        int r;
        send_item(KIND_REWIND, rand_angle(), rand_gyro(), rand_gyro(), 1'b0, '0);
        for (int n = 0; n < rows * JOINTS + extra; n++) begin
            if ($urandom_range(99) < 4) send_noise();
            send_item(KIND_LOAD, rand_angle(), rand_gyro(), rand_gyro(), 1'b0, '0);
        end
        for (int n = 0; n < ticks; n++) begin
            r = $urandom_range(99);
            if (r < 4) send_noise();
            else if (r < 7) send_item(KIND_REWIND, $urandom, $urandom, $urandom, 1'b0, '0);
            else if (r < 10) send_item(KIND_LOAD, rand_angle(), $urandom, $urandom, 1'b0, '0);
            if (row_loaded()) send_item(KIND_TICK, $urandom, rand_gyro(), rand_gyro(), 1'b0, '0);
            else send_noise();
        end
    endtask

    always @(negedge aclk) m_tready <= !rx_hold && ($urandom_range(99) >= r_idle_pct);

    // long receiver hold-off, counted on its own
    always begin
        wait (hold_go);
        @(posedge aclk);
        hold_go = 1'b0;
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    always @(posedge aclk) begin : joint_cmd_check
        joint_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (joint_cmds_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer id %0d", m_tdata[ID_W-1:0]));
            end else begin
                want = joint_cmds_q.pop_front();
                if (m_tdata[ID_W-1:0] !== want.id ||
                    m_tdata[ID_W+POS_W-1:ID_W] !== want.pos ||
                    m_tdata[ID_W+POS_W+PGAIN_W-1:ID_W+POS_W] !== want.gain ||
                    m_tlast !== want.last)
                    flag_mismatch($sformatf("id %0d/%0d pos %0d/%0d gain %0d/%0d last %0b/%0b",
                        m_tdata[ID_W-1:0], want.id,
                        $signed(m_tdata[ID_W+POS_W-1:ID_W]), $signed(want.pos),
                        m_tdata[ID_W+POS_W+PGAIN_W-1:ID_W+POS_W], want.gain,
                        m_tlast, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int goal;
        regs = '{balance_enable: 1'b1, hip_roll_gain: 10'd128, ankle_roll_gain: 10'd256,
                 knee_gain: 10'd77, ankle_pitch_gain: 10'd230, hip_pitch_offset: '0,
                 leg_p_gain: 8'd64, row_count: 9'd1};

        // reset config: row_count 1, so every tick here plays row 0
        steps[0] = '{KIND_NONE,   24'hA5C3F0, 12'hFFF, 12'h800, 5'd1,  1'b0, 19'd0};
        steps[1] = '{KIND_LOAD,   24'h7FFFFF, 12'h000, 12'h000, 5'd16, 1'b0, 19'd0};
        steps[2] = '{KIND_TICK,   24'h000000, 12'h000, 12'h000, 5'd1,  1'b1, 19'h3FFFF};
        steps[3] = '{KIND_TICK,   24'hFFFFFF, 12'h7FF, 12'h800, 5'd1,  1'b0, 19'd0};
        steps[4] = '{KIND_TICK,   24'h5AA5C3, 12'h800, 12'h7FF, 5'd1,  1'b0, 19'd0};
        steps[5] = '{KIND_REWIND, 24'h3C3C3C, 12'hA5A, 12'h5A5, 5'd1,  1'b0, 19'd0};
        steps[6] = '{KIND_LOAD,   24'h800000, 12'h000, 12'h000, 5'd1,  1'b0, 19'd0};
        steps[7] = '{KIND_LOAD,   24'h000000, 12'hFFF, 12'hFFF, 5'd1,  1'b0, 19'd0};
        steps[8] = '{KIND_TICK,   24'h000000, 12'h000, 12'h000, 5'd1,  1'b0, 19'd0};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        s_idle_pct = 29;
        r_idle_pct = 51;
        for (int i = 0; i < 9; i++)
            for (int k = 0; k < steps[i].reps; k++)
                send_item(steps[i].kind, steps[i].angle, steps[i].roll, steps[i].pitch,
                          steps[i].pinned, steps[i].pinned_pos);

        settle();
        program_random(4);
        // receiver holds off while ticks keep coming, so the command queue backs up
        hold_go = 1'b1;
        gait_run(4, 0, 14);
        goal = gait_items + 150;
        while (gait_items < goal) gait_run($urandom_range(1, 5), 0, $urandom_range(1, 8));

        settle();
        program_regs(1, 1023, 1023, 1023, 1023, 251000, 255, 0);   // row_count 0 acts as 1
        goal = gait_items + 80;
        while (gait_items < goal) gait_run(1, $urandom_range(0, 3), $urandom_range(1, 6));

        s_idle_pct = 51;
        r_idle_pct = 29;
        settle();
        program_regs(0, 0, 0, 0, 0, -251000, 0, 3);
        goal = gait_items + 80;
        while (gait_items < goal) gait_run($urandom_range(1, 4), 0, $urandom_range(1, 8));

        // full table with pointer wrap; row_count beyond the table and play row held at the end
        settle();
        program_random(511);
        gait_run(ROWS_MAX, 4, ROWS_MAX + 14);

        // whole table is written from here on, any row count is safe
        s_idle_pct = 0;
        r_idle_pct = 0;
        settle();
        program_random($urandom_range(1, 300));
        goal = gait_items + 60;
        while (gait_items < goal) gait_run($urandom_range(1, 6), 0, $urandom_range(1, 10));

        settle();
        program_regs(1, $urandom_range(1023), 512, $urandom_range(1023), 1023,
                     int'($urandom_range(2000)) - 1000, $urandom_range(255), 256);
        goal = gait_items + 60;
        while (gait_items < goal) gait_run($urandom_range(1, 3), 0, $urandom_range(1, 12));

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: gait_playback_gyro_balance.f
rtl/gpgb_pkg.sv
rtl/gpgb_queue.sv
rtl/gpgb_front.sv
rtl/gpgb_gyro.sv
rtl/gpgb_back.sv
rtl/gait_playback_gyro_balance.sv
sim/tb_top.sv
